>>> rtl/core/etsc_pkg.sv
package etsc_pkg;

  localparam int FREQ_W  = 27;
  localparam int CORR_W  = 31;
  localparam int STEP_W  = 20;
  localparam int IDX_W   = 3;
  localparam int CLS_W   = 2;
  localparam int IVL_W   = 16;
  localparam int CMD_W   = 2;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 31;

  // commands
  localparam logic [CMD_W-1:0] CMD_CW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CCW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_SLOW_BORDER = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MID_BORDER  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_FAST_BORDER = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_FREQ_MIN    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_FREQ_MAX    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_START_FREQ  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_START_CORR  = 3'd6;

  // register and state defaults
  localparam logic [IVL_W-1:0]  SLOW_BORDER_RST = 16'd300;
  localparam logic [IVL_W-1:0]  MID_BORDER_RST  = 16'd75;
  localparam logic [IVL_W-1:0]  FAST_BORDER_RST = 16'd25;
  localparam logic [FREQ_W-1:0] FREQ_MIN_RST    = 27'd100000;
  localparam logic [FREQ_W-1:0] FREQ_MAX_RST    = 27'd100000000;
  localparam logic [FREQ_W-1:0] START_FREQ_RST  = 27'd10000000;
  localparam logic [CORR_W-1:0] START_CORR_RST  = 31'd215000;
  localparam logic [IDX_W-1:0]  AUTO_INDEX      = 3'd7;
  localparam logic [CLS_W-1:0]  CLS_SLOW        = 2'd0;
  localparam logic [CLS_W-1:0]  CLS_MID         = 2'd1;
  localparam logic [CLS_W-1:0]  CLS_FAST        = 2'd2;
  localparam logic [CLS_W-1:0]  CLS_TURBO       = 2'd3;

  // dividend of the round-down: old frequency plus one step
  localparam int DIV_BITS = FREQ_W + 1;
  localparam int CNT_W    = $clog2(DIV_BITS + 1);

  // microcode
  localparam int UPC_W  = 4;
  localparam int OP_W   = 4;
  localparam int COND_W = 3;

  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH   = 4'd1;
  localparam logic [OP_W-1:0] OP_LDSTEP  = 4'd2;
  localparam logic [OP_W-1:0] OP_TADD    = 4'd3;
  localparam logic [OP_W-1:0] OP_DIVB    = 4'd4;
  localparam logic [OP_W-1:0] OP_ROUND   = 4'd5;
  localparam logic [OP_W-1:0] OP_TCOMMIT = 4'd6;
  localparam logic [OP_W-1:0] OP_CORR    = 4'd7;
  localparam logic [OP_W-1:0] OP_MISC    = 4'd8;
  localparam logic [OP_W-1:0] OP_OUT     = 4'd9;

  localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] C_NO_IN    = 3'd2;
  localparam logic [COND_W-1:0] C_NOT_TICK = 3'd3;
  localparam logic [COND_W-1:0] C_SETUP    = 3'd4;
  localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd5;
  localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd6;

  localparam logic [UPC_W-1:0] UPC_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] UPC_SPLIT  = 4'd2;
  localparam logic [UPC_W-1:0] UPC_DIV    = 4'd4;
  localparam logic [UPC_W-1:0] UPC_CORR   = 4'd7;
  localparam logic [UPC_W-1:0] UPC_MISC   = 4'd8;
  localparam logic [UPC_W-1:0] UPC_OUT    = 4'd9;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IVL_W-1:0] interval_ms;
    logic             setup_mode;
  } etsc_in_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [CORR_W-1:0] correction;
    logic [IDX_W-1:0]  step_select;
    logic [STEP_W-1:0] active_step;
    logic              retune;
  } etsc_out_t;

  typedef struct packed {
    logic              in_rdy;
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic no_in;
    logic not_tick;
    logic setup;
    logic div_busy;
    logic out_busy;
  } cond_t;

  function automatic uword_t mk(input logic rdy, input logic [OP_W-1:0] op,
                                input logic [COND_W-1:0] cond,
                                input logic [UPC_W-1:0] target);
    uword_t w;
    w.in_rdy = rdy;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = mk(1'b1, OP_LATCH,   C_NO_IN,    UPC_IDLE);
      4'd1:    w = mk(1'b0, OP_LDSTEP,  C_NOT_TICK, UPC_MISC);
      4'd2:    w = mk(1'b0, OP_NOP,     C_SETUP,    UPC_CORR);
      4'd3:    w = mk(1'b0, OP_TADD,    C_NEVER,    UPC_IDLE);
      4'd4:    w = mk(1'b0, OP_DIVB,    C_DIV_BUSY, UPC_DIV);
      4'd5:    w = mk(1'b0, OP_ROUND,   C_NEVER,    UPC_IDLE);
      4'd6:    w = mk(1'b0, OP_TCOMMIT, C_ALWAYS,   UPC_OUT);
      4'd7:    w = mk(1'b0, OP_CORR,    C_ALWAYS,   UPC_OUT);
      4'd8:    w = mk(1'b0, OP_MISC,    C_NEVER,    UPC_IDLE);
      4'd9:    w = mk(1'b0, OP_OUT,     C_OUT_BUSY, UPC_OUT);
      4'd10:   w = mk(1'b0, OP_NOP,     C_ALWAYS,   UPC_IDLE);
      default: w = mk(1'b0, OP_NOP,     C_ALWAYS,   UPC_IDLE);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/encoder_tuning_step_controller_core.sv
// One item is handled at a time: a new item is taken only after the last one's
// result is loaded. A tune tick runs the bit-serial round-down remainder; a
// correction tick, step press or idle-save event skips it. Any item may also wait
// for the previous result to be taken.
// Reset (rst, synchronous, active high) restores register defaults, loads the
// default start frequency and correction, step index 0 and the 100 Hz class.
module encoder_tuning_step_controller_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  etsc_pkg::etsc_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output etsc_pkg::etsc_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [etsc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [etsc_pkg::CFG_DW-1:0] cfg_wdata
);
  import etsc_pkg::*;

  // Control word from the sequencer and branch conditions back from the
  // datapath. The sequencer steps through a fixed program:
  //   idle/latch -> load step -> split on command and mode
  //   tune:  add or subtract step, 28 remainder steps, subtract remainder,
  //          range check and commit
  //   setup: saturating correction update
  //   other: advance step index or drop speed class to slow
  //   then load the output register (hold while the previous item waits).
  uword_t uword;
  cond_t  cond;

  // The idle step is the only one that takes an item.
  assign in_ready = uword.in_rdy;

  etsc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .cond  (cond),
    .uword (uword)
  );

  etsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .uword     (uword),
    .cond      (cond),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // After taking an item, the sequencer must leave the idle step.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer stayed idle after taking an item");

  // A new result appears only from the output step.
  a_out_from_ustep: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(uword.op == OP_OUT))
    else $error("result raised outside the output step");

  // The reported step is never zero.
  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.active_step != '0))
    else $error("zero active step on output");

endmodule

>>> rtl/core/etsc_seq.sv
module etsc_seq (
  input  logic            clk,
  input  logic            rst,
  input  etsc_pkg::cond_t cond,
  output etsc_pkg::uword_t uword
);
  import etsc_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             take;

  assign uword = ucode(upc);

  always_comb begin
    case (uword.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = cond.no_in;
      C_NOT_TICK: take = cond.not_tick;
      C_SETUP:    take = cond.setup;
      C_DIV_BUSY: take = cond.div_busy;
      C_OUT_BUSY: take = cond.out_busy;
      default:    take = 1'b1;
    endcase
    upc_next = take ? uword.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

>>> rtl/core/etsc_dp.sv
module etsc_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  etsc_pkg::uword_t                   uword,
  output etsc_pkg::cond_t                    cond,
  input  logic                               in_valid,
  input  etsc_pkg::etsc_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output etsc_pkg::etsc_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [etsc_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [etsc_pkg::CFG_DW-1:0]        cfg_wdata
);
  import etsc_pkg::*;

  // configuration
  logic [IVL_W-1:0]  slow_border, mid_border, fast_border;
  logic [FREQ_W-1:0] freq_min, freq_max;

  // architectural state
  logic [FREQ_W-1:0] tuned_freq;
  logic [CORR_W-1:0] corr_value;
  logic [IDX_W-1:0]  step_index;
  logic [CLS_W-1:0]  speed_class;

  // per-item scratch
  logic [CMD_W-1:0]    cmd;
  logic [IVL_W-1:0]    interval;
  logic                setup;
  logic [STEP_W-1:0]   step;
  logic [DIV_BITS-1:0] nval;
  logic [DIV_BITS-1:0] quo;
  logic [STEP_W-1:0]   rem;
  logic [CNT_W-1:0]    cnt;
  logic                bad;
  logic                retune;

  logic [DIV_BITS-1:0] old_ext;
  logic [DIV_BITS-1:0] step_ext;
  logic [DIV_BITS-1:0] sum;
  logic [STEP_W:0]     trial;
  logic                trial_ge;
  logic                in_range;
  logic [CORR_W:0]     corr_sum;
  logic [CLS_W-1:0]    new_class;
  logic                out_busy;

  function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] idx,
                                                input logic [CLS_W-1:0] cls);
    logic [STEP_W-1:0] s;
    if (idx == AUTO_INDEX) begin
      case (cls)
        CLS_SLOW:  s = 20'd10;
        CLS_MID:   s = 20'd100;
        CLS_FAST:  s = 20'd1000;
        CLS_TURBO: s = 20'd25000;
        default:   s = 20'd10;
      endcase
    end else begin
      case (idx)
        3'd0:    s = 20'd1000000;
        3'd1:    s = 20'd100000;
        3'd2:    s = 20'd10000;
        3'd3:    s = 20'd1000;
        3'd4:    s = 20'd100;
        3'd5:    s = 20'd10;
        3'd6:    s = 20'd1;
        default: s = 20'd1;
      endcase
    end
    return s;
  endfunction

  assign old_ext  = {1'b0, tuned_freq};
  assign step_ext = {{(DIV_BITS-STEP_W){1'b0}}, step};
  assign sum      = cmd[0] ? old_ext - step_ext : old_ext + step_ext;
  assign trial    = {rem, quo[DIV_BITS-1]};
  assign trial_ge = trial >= {1'b0, step};
  assign in_range = !bad && (nval <= {1'b0, freq_max}) && (nval >= {1'b0, freq_min});
  assign corr_sum = {1'b0, corr_value} + {{(CORR_W+1-STEP_W){1'b0}}, step};

  always_comb begin
    if (interval > slow_border) begin
      new_class = CLS_SLOW;
    end else if (interval > mid_border) begin
      new_class = CLS_MID;
    end else if (interval > fast_border) begin
      new_class = CLS_FAST;
    end else begin
      new_class = CLS_TURBO;
    end
  end

  assign out_busy      = out_valid && !out_ready;
  assign cond.no_in    = !in_valid;
  assign cond.not_tick = cmd[1];
  assign cond.setup    = setup;
  assign cond.div_busy = cnt != CNT_W'(1);
  assign cond.out_busy = out_busy;

  // configuration; start-value writes are ignored, and reset restores defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_border <= SLOW_BORDER_RST;
      mid_border  <= MID_BORDER_RST;
      fast_border <= FAST_BORDER_RST;
      freq_min    <= FREQ_MIN_RST;
      freq_max    <= FREQ_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOW_BORDER: slow_border <= cfg_wdata[IVL_W-1:0];
        CFG_MID_BORDER:  mid_border  <= cfg_wdata[IVL_W-1:0];
        CFG_FAST_BORDER: fast_border <= cfg_wdata[IVL_W-1:0];
        CFG_FREQ_MIN:    freq_min    <= cfg_wdata[FREQ_W-1:0];
        CFG_FREQ_MAX:    freq_max    <= cfg_wdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tuned_freq  <= START_FREQ_RST;
      corr_value  <= START_CORR_RST;
      step_index  <= '0;
      speed_class <= CLS_MID;
      retune      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      case (uword.op)
        OP_LATCH: begin
          retune <= 1'b0;
        end
        OP_TCOMMIT: begin
          if (in_range) begin
            tuned_freq <= nval[FREQ_W-1:0];
            retune     <= nval[FREQ_W-1:0] != tuned_freq;
          end
          speed_class <= new_class;
        end
        OP_CORR: begin
          if (!cmd[0]) begin
            corr_value <= corr_sum[CORR_W] ? {CORR_W{1'b1}} : corr_sum[CORR_W-1:0];
          end else if (corr_value < {{(CORR_W-STEP_W){1'b0}}, step}) begin
            corr_value <= '0;
          end else begin
            corr_value <= corr_value - {{(CORR_W-STEP_W){1'b0}}, step};
          end
          speed_class <= new_class;
        end
        OP_MISC: begin
          if (cmd == CMD_STEP) begin
            step_index <= step_index + 1'b1;
          end else begin
            speed_class <= CLS_SLOW;
          end
        end
        default: ;
      endcase
      if (uword.op == OP_OUT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scratch and output payload
  always_ff @(posedge clk) begin
    case (uword.op)
      OP_LATCH: begin
        if (in_valid) begin
          cmd      <= in_data.command;
          interval <= in_data.interval_ms;
          setup    <= in_data.setup_mode;
        end
      end
      OP_LDSTEP: begin
        step <= step_of(step_index, speed_class);
      end
      OP_TADD: begin
        nval <= sum;
        quo  <= sum;
        bad  <= cmd[0] && (old_ext < step_ext);
        rem  <= '0;
        cnt  <= CNT_W'(DIV_BITS);
      end
      OP_DIVB: begin
        rem <= trial_ge ? STEP_W'(trial - {1'b0, step}) : trial[STEP_W-1:0];
        quo <= {quo[DIV_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      OP_ROUND: begin
        nval <= nval - {{(DIV_BITS-STEP_W){1'b0}}, rem};
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_data.frequency   <= tuned_freq;
          out_data.correction  <= corr_value;
          out_data.step_select <= step_index;
          out_data.active_step <= step_of(step_index, speed_class);
          out_data.retune      <= retune;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> bench/tb_encoder_tuning_step_controller_core.sv
`timescale 1ns / 1ps

module tb_encoder_tuning_step_controller_core;
  import etsc_pkg::*;

  // unused register slot: writes to it must leave every setting alone
  localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;
  localparam logic [63:0] CORR_CEIL = 64'h7FFF_FFFF;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 75;
  localparam int CALM_ITEMS    = 40;
  localparam int PARK_CYCLES   = 400;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int PROBES        = 25;

  typedef struct packed {
    etsc_in_t  ev;
    logic      pinned;
    etsc_out_t want;
  } probe_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  etsc_in_t            in_data;
  logic                out_valid;
  logic                out_ready;
  etsc_out_t           out_data;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;

  // mirror of the block: settings and tuning state
  logic [IVL_W-1:0]    cfg_slow, cfg_mid, cfg_fast;
  logic [FREQ_W-1:0]   cfg_fmin, cfg_fmax;
  logic [FREQ_W-1:0]   st_freq;
  logic [CORR_W-1:0]   st_corr;
  logic [IDX_W-1:0]    st_idx;
  logic [CLS_W-1:0]    st_cls;

  // readouts the block still owes, oldest first
  etsc_out_t           readouts_due[$];
  etsc_out_t           due_head;
  probe_row_t          probe_tab [PROBES];

  int                  fault_count = 0;
  int                  quiet_cycles = 0;
  bit                  park_now = 1'b0;
  bit                  calm = 1'b0;
  int                  down_pct = 50;
  int                  setup_pct = 15;
  int                  press_pct = 12;

  encoder_tuning_step_controller_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Step size in hertz for a step index and speed class.
  function automatic logic [STEP_W-1:0] step_hz(input logic [IDX_W-1:0] idx,
                                                 input logic [CLS_W-1:0] cls);
    logic [STEP_W-1:0] hz;
    if (idx == AUTO_INDEX) begin
      case (cls)
        CLS_SLOW: hz = 20'd10;
        CLS_MID:  hz = 20'd100;
        CLS_FAST: hz = 20'd1000;
        default:  hz = 20'd25000;
      endcase
    end else begin
      case (idx)
        3'd0:    hz = 20'd1000000;
        3'd1:    hz = 20'd100000;
        3'd2:    hz = 20'd10000;
        3'd3:    hz = 20'd1000;
        3'd4:    hz = 20'd100;
        3'd5:    hz = 20'd10;
        default: hz = 20'd1;
      endcase
    end
    return hz;
  endfunction

  // Borders form a priority chain; slow wins first, even if unordered.
  function automatic logic [CLS_W-1:0] speed_of(input logic [IVL_W-1:0] ms);
    if (ms > cfg_slow)      return CLS_SLOW;
    else if (ms > cfg_mid)  return CLS_MID;
    else if (ms > cfg_fast) return CLS_FAST;
    else                    return CLS_TURBO;
  endfunction

  // Advance the mirrored state by one event and return the readout it produces.
  function automatic etsc_out_t apply_encoder_event(input etsc_in_t ev);
    logic [63:0] s, old, n, c;
    logic        bad, moved;
    etsc_out_t   r;
    s     = 64'(step_hz(st_idx, st_cls));
    n     = '0;
    bad   = 1'b0;
    moved = 1'b0;
    if (ev.command == CMD_CW || ev.command == CMD_CCW) begin
      if (!ev.setup_mode) begin
        old = 64'(st_freq);
        if (ev.command == CMD_CW) n = old + s;
        else if (old < s)         bad = 1'b1;
        else                      n = old - s;
        n = (n / s) * s;
        // an underflow or a landing outside the limits keeps the old frequency
        if (bad || n > cfg_fmax || n < cfg_fmin) n = old;
        moved   = (n != old);
        st_freq = n[FREQ_W-1:0];
      end else begin
        c = 64'(st_corr);
        if (ev.command == CMD_CW) c = (c + s > CORR_CEIL) ? CORR_CEIL : c + s;
        else                      c = (c < s) ? 64'd0 : c - s;
        st_corr = c[CORR_W-1:0];
      end
      // the tick used the old class; the interval sets the next one
      st_cls = speed_of(ev.interval_ms);
    end else if (ev.command == CMD_STEP) begin
      st_idx = st_idx + 1'b1;
    end else begin
      st_cls = CLS_SLOW;
    end
    r.frequency   = st_freq;
    r.correction  = st_corr;
    r.step_select = st_idx;
    r.active_step = step_hz(st_idx, st_cls);
    r.retune      = moved;
    return r;
  endfunction

  function automatic probe_row_t probe(input logic [CMD_W-1:0] cmd,
                                       input logic [IVL_W-1:0] ms,
                                       input logic setup, input logic pinned,
                                       input logic [FREQ_W-1:0] f,
                                       input logic [CORR_W-1:0] c,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [STEP_W-1:0] hz,
                                       input logic rt);
    probe_row_t row;
    row.ev.command          = cmd;
    row.ev.interval_ms      = ms;
    row.ev.setup_mode       = setup;
    row.pinned              = pinned;
    row.want.frequency      = f;
    row.want.correction     = c;
    row.want.step_select    = idx;
    row.want.active_step    = hz;
    row.want.retune         = rt;
    return row;
  endfunction

  // Random event: mostly ticks, intervals clustered on the borders.
  function automatic etsc_in_t draw_event();
    etsc_in_t ev;
    int       roll;
    int       rim;
    roll = int'($urandom_range(0, 99));
    if (roll < press_pct)          ev.command = CMD_STEP;
    else if (roll < press_pct + 5) ev.command = CMD_IDLE;
    else ev.command = ($urandom_range(0, 99) < down_pct) ? CMD_CCW : CMD_CW;
    ev.setup_mode = ($urandom_range(0, 99) < setup_pct);
    rim = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 6))
      0:       ev.interval_ms = '0;
      1:       ev.interval_ms = '1;
      2:       ev.interval_ms = IVL_W'(int'(cfg_slow) + rim);
      3:       ev.interval_ms = IVL_W'(int'(cfg_mid) + rim);
      4:       ev.interval_ms = IVL_W'(int'(cfg_fast) + rim);
      default: ev.interval_ms = IVL_W'($urandom);
    endcase
    return ev;
  endfunction

  // Offer one item and hold it until accepted; log what it should produce.
  task automatic offer(input etsc_in_t ev, input logic pinned, input etsc_out_t want);
    etsc_out_t calc;
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = apply_encoder_event(ev);
    readouts_due.push_back(pinned ? want : calc);
  endtask

  // Drop valid for a short burst; half the time line it up with the block
  // going idle so the gap lands on the accept phase instead of the busy one.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        while (readouts_due.size() != 0) @(posedge clk);
      end
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic offer_random();
    offer(draw_event(), 1'b0, '0);
    sender_gap();
  endtask

  // Drop valid and wait until the block has handed over every readout.
  task automatic settle();
    in_valid <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_SLOW_BORDER: cfg_slow   = val[IVL_W-1:0];
      CFG_MID_BORDER:  cfg_mid    = val[IVL_W-1:0];
      CFG_FAST_BORDER: cfg_fast   = val[IVL_W-1:0];
      CFG_FREQ_MIN:    cfg_fmin   = val[FREQ_W-1:0];
      CFG_FREQ_MAX:    cfg_fmax   = val[FREQ_W-1:0];
      default: ;
    endcase
  endtask

  // Load one setting of borders and limits, chosen around the current frequency.
  task automatic load_setting(input int p);
    logic [IVL_W-1:0]  b0, b1, b2, t;
    logic [CFG_DW-1:0] lo, hi, sf, sc, junk;
    int                cur, d;
    cur  = int'(st_freq);
    d    = int'($urandom_range(0, 3000000));
    b0   = IVL_W'($urandom);
    b1   = IVL_W'($urandom);
    b2   = IVL_W'($urandom);
    sf   = CFG_DW'($urandom);
    sc   = CFG_DW'($urandom);
    junk = CFG_DW'($urandom);
    lo   = CFG_DW'((cur > d) ? cur - d : 0);
    hi   = CFG_DW'(cur + int'($urandom_range(0, 3000000)));
    case (p)
      0: begin
        b0 = '0; b1 = '0; b2 = '0;
        sf = '0; sc = '0;
      end
      1: begin
        b0 = '1; b1 = '1; b2 = '1;
        sf = '1; sc = '1;
      end
      2: begin
        // sort so the chain is well ordered
        if (b0 < b1) begin t = b0; b0 = b1; b1 = t; end
        if (b1 < b2) begin t = b1; b1 = b2; b2 = t; end
        if (b0 < b1) begin t = b0; b0 = b1; b1 = t; end
      end
      3: begin
        // floor at zero so downward ticks can run off the bottom
        lo = '0;
        hi = CFG_DW'(cur + 1000000);
      end
      4: begin
        // full-width write; upper bits must be masked off
        lo = '0;
        hi = '1;
      end
      5: begin
        // ceiling below the current frequency: tuned value starts out of range
        hi = CFG_DW'((cur > 500000) ? cur - int'($urandom_range(1, 500000)) : 0);
        lo = CFG_DW'((cur > 5000000) ? cur - 5000000 : 0);
      end
      6: begin
        lo = '1;
        hi = '1;
      end
      default: begin
        b0 = SLOW_BORDER_RST;
        b1 = MID_BORDER_RST;
        b2 = FAST_BORDER_RST;
        lo = CFG_DW'(FREQ_MIN_RST);
        hi = CFG_DW'(FREQ_MAX_RST);
      end
    endcase
    cfg_write(CFG_SLOW_BORDER, {junk[CFG_DW-1:IVL_W], b0});
    cfg_write(CFG_MID_BORDER,  {junk[CFG_DW-1:IVL_W], b1});
    cfg_write(CFG_FAST_BORDER, {junk[CFG_DW-1:IVL_W], b2});
    cfg_write(CFG_FREQ_MIN,    lo);
    cfg_write(CFG_FREQ_MAX,    hi);
    cfg_write(CFG_START_FREQ,  sf);
    cfg_write(CFG_START_CORR,  sc);
    cfg_write(CFG_UNUSED,      CFG_DW'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (park_now) begin
        park_now = 1'b0;
        out_ready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each readout, field by field, against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (readouts_due.size() == 0) begin
        $error("readout with no item pending: frequency %0d", out_data.frequency);
        fault_count++;
      end else begin
        due_head = readouts_due.pop_front();
        if (out_data.frequency !== due_head.frequency) begin
          $error("frequency: expected %0d, got %0d", due_head.frequency, out_data.frequency);
          fault_count++;
        end
        if (out_data.correction !== due_head.correction) begin
          $error("correction: expected %0d, got %0d", due_head.correction,
                 out_data.correction);
          fault_count++;
        end
        if (out_data.step_select !== due_head.step_select) begin
          $error("step_select: expected %0d, got %0d", due_head.step_select,
                 out_data.step_select);
          fault_count++;
        end
        if (out_data.active_step !== due_head.active_step) begin
          $error("active_step: expected %0d, got %0d", due_head.active_step,
                 out_data.active_step);
          fault_count++;
        end
        if (out_data.retune !== due_head.retune) begin
          $error("retune: expected %0d, got %0d", due_head.retune, out_data.retune);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    etsc_in_t press;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;

    // mirror the reset state
    cfg_slow   = SLOW_BORDER_RST;
    cfg_mid    = MID_BORDER_RST;
    cfg_fast   = FAST_BORDER_RST;
    cfg_fmin   = FREQ_MIN_RST;
    cfg_fmax   = FREQ_MAX_RST;
    st_freq    = START_FREQ_RST;
    st_corr    = START_CORR_RST;
    st_idx     = '0;
    st_cls     = CLS_MID;

    // Directed rows: the first few read straight off the reset defaults.
    probe_tab[0]  = probe(CMD_IDLE, 16'hFFFF, 1'b0, 1'b1,
                          27'd10000000, 31'd215000, 3'd0, 20'd1000000, 1'b0);
    probe_tab[1]  = probe(CMD_CW, 16'd0, 1'b0, 1'b1,
                          27'd11000000, 31'd215000, 3'd0, 20'd1000000, 1'b1);
    probe_tab[2]  = probe(CMD_CCW, 16'hFFFF, 1'b0, 1'b1,
                          27'd10000000, 31'd215000, 3'd0, 20'd1000000, 1'b1);
    probe_tab[3]  = probe(CMD_CW, 16'd300, 1'b1, 1'b1,
                          27'd10000000, 31'd1215000, 3'd0, 20'd1000000, 1'b0);
    probe_tab[4]  = probe(CMD_CCW, 16'd301, 1'b1, 1'b1,
                          27'd10000000, 31'd215000, 3'd0, 20'd1000000, 1'b0);
    // correction clamps at zero
    probe_tab[5]  = probe(CMD_CCW, 16'd76, 1'b1, 1'b1,
                          27'd10000000, 31'd0, 3'd0, 20'd1000000, 1'b0);
    probe_tab[6]  = probe(CMD_STEP, 16'd0, 1'b0, 1'b1,
                          27'd10000000, 31'd0, 3'd1, 20'd100000, 1'b0);
    // walk the fixed decades down to 1 Hz
    probe_tab[7]  = probe(CMD_STEP, 16'd5, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[8]  = probe(CMD_STEP, 16'd1000, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[9]  = probe(CMD_STEP, 16'd0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[10] = probe(CMD_STEP, 16'd40000, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[11] = probe(CMD_STEP, 16'hFFFF, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[12] = probe(CMD_CW, 16'd75, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    // into auto step: class picks 10/100/1000/25000 and rounding kicks in
    probe_tab[13] = probe(CMD_STEP, 16'd0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[14] = probe(CMD_CW, 16'd25, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[15] = probe(CMD_CW, 16'd26, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[16] = probe(CMD_CCW, 16'd0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[17] = probe(CMD_IDLE, 16'd0, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[18] = probe(CMD_CW, 16'hFFFF, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[19] = probe(CMD_CCW, 16'd0, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[20] = probe(CMD_CCW, 16'd0, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    // index wraps back to 1 MHz, then a tick rounds down to the decade
    probe_tab[21] = probe(CMD_STEP, 16'd0, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[22] = probe(CMD_CW, 16'd1, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[23] = probe(CMD_CCW, 16'd301, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    probe_tab[24] = probe(CMD_IDLE, 16'hFFFF, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PROBES; i++) begin
      offer(probe_tab[i].ev, probe_tab[i].pinned, probe_tab[i].want);
      sender_gap();
    end

    press.command     = CMD_STEP;
    press.interval_ms = '0;
    press.setup_mode  = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_setting(p);
      case (p)
        3:       begin down_pct = 90; setup_pct = 5;  press_pct = 2;  end
        4:       begin down_pct = 10; setup_pct = 5;  press_pct = 2;  end
        6:       begin down_pct = 50; setup_pct = 60; press_pct = 12; end
        default: begin down_pct = 50; setup_pct = 15; press_pct = 12; end
      endcase
      // coarse phases start at the 1 MHz step so the limits are reached quickly
      if (p == 3 || p == 4) begin
        while (st_idx != '0) begin
          offer(press, 1'b0, '0);
          sender_gap();
        end
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 20) park_now = 1'b1;
        offer_random();
      end
    end

    // last stretch: no idling on either side
    calm = 1'b1;
    down_pct  = 50;
    setup_pct = 15;
    press_pct = 12;
    for (int k = 0; k < CALM_ITEMS; k++) offer_random();

    in_valid <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
